### src/half_single_float_converter_assert.svh
// Assertion macros for the half/single float converter.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef HALF_SINGLE_FLOAT_CONVERTER_ASSERT_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HSFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsfc same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HSFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsfc next-cycle check failed");

`endif

### src/hsfc_pkg.sv
// Shared types and constants for the half/single float converter.
// No dependencies; used by hsfc_lzc10 and half_single_float_converter.
package hsfc_pkg;

  // Conversion direction carried with each transaction.
  typedef enum logic {
    OP_H2S = 1'b0,
    OP_S2H = 1'b1
  } op_t;

  // Operand class decided in the first stage.
  typedef enum logic [2:0] {
    CLS_ZERO = 3'd0,
    CLS_SUB  = 3'd1,
    CLS_NORM = 3'd2,
    CLS_SPEC = 3'd3,
    CLS_INF  = 3'd4,
    CLS_NAN  = 3'd5
  } cls_t;

  localparam int unsigned HalfFracW = 10;
  localparam int unsigned LzW       = 4;

  // Difference between the single bias (127) and the half bias (15).
  localparam logic [7:0] EXP_REBIAS     = 8'd112;
  // Smallest single exponent that no longer fits a half (half exponent 31).
  localparam logic [7:0] S2H_OVF_EXP    = 8'd143;
  localparam logic [7:0] SINGLE_EXP_MAX = 8'hff;
  localparam logic [4:0] HALF_EXP_MAX   = 5'h1f;
  localparam logic [9:0] HALF_NAN_FRAC  = 10'h001;

endpackage

### src/hsfc_lzc10.sv
// Leading-zero counter for the 10-bit half fraction.
// Depends on hsfc_pkg for the field widths.
module hsfc_lzc10 (
  input  logic [hsfc_pkg::HalfFracW-1:0] frac,
  output logic [hsfc_pkg::LzW-1:0]       count
);

  // Priority scan from the least significant bit upward, so the highest set bit wins.
  always_comb begin
    count = hsfc_pkg::LzW'(hsfc_pkg::HalfFracW - 1);
    for (int i = 0; i < hsfc_pkg::HalfFracW; i++) begin
      if (frac[i]) begin
        count = hsfc_pkg::LzW'(hsfc_pkg::HalfFracW - 1 - i);
      end
    end
  end

endmodule

### src/half_single_float_converter.sv
// Top level of the half/single float converter: three-stage conversion pipeline.
// Depends on hsfc_pkg, hsfc_lzc10 and half_single_float_converter_assert.svh.
//
//   Channel | Signals                                   | Role
//   --------+-------------------------------------------+---------
//   input   | in_valid, in_stall, operation, operand_bits | operand
//   output  | out_valid, out_stall, result_bits         | result
//
// A transaction passes through the three pipeline registers in order, stage 1, stage 2 and stage 3,
// and is offered on result_bits from the stage 3 register until out_stall lets it be taken.
// One transaction is accepted per cycle while in_stall is low, since every stage loads
// whenever it is empty or the stage after it moves.
// Reset clears the stage valid bits only; datapath registers are not reset.
// A stage holds while the stage after it is full and held; bubbles are squeezed out,
// so in_stall rises only when all three stages are full and out_stall is high.
`include "half_single_float_converter_assert.svh"

module half_single_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_bits
);

  // Stage enables: a stage loads when it is empty or the next stage loads.
  logic en1, en2, en3;
  logic v1, v2, v3;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1: classify the operand and count leading zeros of a half fraction.
  hsfc_pkg::op_t  op_in;
  hsfc_pkg::cls_t cls_next;
  logic [7:0]     exp_next;
  logic [9:0]     frac_next;
  logic           sign_next;
  logic [hsfc_pkg::LzW-1:0] lz_next;

  assign op_in = hsfc_pkg::op_t'(operation);

  always_comb begin
    unique case (op_in)
      hsfc_pkg::OP_H2S: begin
        sign_next = operand_bits[15];
        exp_next  = {3'b000, operand_bits[14:10]};
        frac_next = operand_bits[9:0];
        if (operand_bits[14:10] == 5'd0) begin
          cls_next = (operand_bits[9:0] == 10'd0) ? hsfc_pkg::CLS_ZERO : hsfc_pkg::CLS_SUB;
        end else if (operand_bits[14:10] == hsfc_pkg::HALF_EXP_MAX) begin
          cls_next = hsfc_pkg::CLS_SPEC;
        end else begin
          cls_next = hsfc_pkg::CLS_NORM;
        end
      end
      default: begin
        sign_next = operand_bits[31];
        exp_next  = operand_bits[30:23];
        frac_next = operand_bits[22:13];
        if (operand_bits[30:23] == hsfc_pkg::SINGLE_EXP_MAX) begin
          cls_next = (operand_bits[22:0] != 23'd0) ? hsfc_pkg::CLS_NAN : hsfc_pkg::CLS_INF;
        end else if (operand_bits[30:23] >= hsfc_pkg::S2H_OVF_EXP) begin
          cls_next = hsfc_pkg::CLS_INF;
        end else if (operand_bits[30:23] <= hsfc_pkg::EXP_REBIAS) begin
          cls_next = hsfc_pkg::CLS_ZERO;
        end else begin
          cls_next = hsfc_pkg::CLS_NORM;
        end
      end
    endcase
  end

  hsfc_lzc10 u_lzc (
    .frac  (operand_bits[9:0]),
    .count (lz_next)
  );

  hsfc_pkg::op_t  op1;
  hsfc_pkg::cls_t cls1;
  logic [7:0]     exp1;
  logic [9:0]     frac1;
  logic           sign1;
  logic [hsfc_pkg::LzW-1:0] lz1;

  always_ff @(posedge clk) begin
    if (en1) begin
      op1   <= op_in;
      cls1  <= cls_next;
      exp1  <= exp_next;
      frac1 <= frac_next;
      sign1 <= sign_next;
      lz1   <= lz_next;
    end
  end

  // Stage 2: rebias the exponent and normalize a half subnormal fraction.
  logic [7:0] exp2_next;
  logic [9:0] frac2_next;
  logic [9:0] frac_sh;

  assign frac_sh = frac1 << lz1;

  always_comb begin
    exp2_next  = exp1;
    frac2_next = frac1;
    unique case (op1)
      hsfc_pkg::OP_H2S: begin
        if (cls1 == hsfc_pkg::CLS_SUB) begin
          // The leading one becomes implicit, so shift one place past it.
          exp2_next  = hsfc_pkg::EXP_REBIAS - {4'd0, lz1};
          frac2_next = {frac_sh[8:0], 1'b0};
        end else if (cls1 == hsfc_pkg::CLS_SPEC) begin
          exp2_next = hsfc_pkg::SINGLE_EXP_MAX;
        end else begin
          exp2_next = exp1 + hsfc_pkg::EXP_REBIAS;
        end
      end
      default: begin
        exp2_next = exp1 - hsfc_pkg::EXP_REBIAS;
      end
    endcase
  end

  hsfc_pkg::op_t  op2;
  hsfc_pkg::cls_t cls2;
  logic [7:0]     exp2;
  logic [9:0]     frac2;
  logic           sign2;

  always_ff @(posedge clk) begin
    if (en2) begin
      op2   <= op1;
      cls2  <= cls1;
      exp2  <= exp2_next;
      frac2 <= frac2_next;
      sign2 <= sign1;
    end
  end

  // Stage 3: pack the result word.
  logic [31:0] result_next;

  always_comb begin
    unique case (op2)
      hsfc_pkg::OP_H2S: begin
        if (cls2 == hsfc_pkg::CLS_ZERO) begin
          result_next = {sign2, 31'd0};
        end else begin
          result_next = {sign2, exp2, frac2, 13'd0};
        end
      end
      default: begin
        case (cls2)
          hsfc_pkg::CLS_NAN:
            result_next = {16'd0, sign2, hsfc_pkg::HALF_EXP_MAX, hsfc_pkg::HALF_NAN_FRAC};
          hsfc_pkg::CLS_INF:
            result_next = {16'd0, sign2, hsfc_pkg::HALF_EXP_MAX, 10'd0};
          hsfc_pkg::CLS_NORM:
            result_next = {16'd0, sign2, exp2[4:0], frac2};
          default:
            result_next = {16'd0, sign2, 15'd0};
        endcase
      end
    endcase
  end

  hsfc_pkg::op_t op3;
  logic [31:0]   result3;

  always_ff @(posedge clk) begin
    if (en3) begin
      op3     <= op2;
      result3 <= result_next;
    end
  end

  assign out_valid   = v3;
  assign result_bits = result3;

  // A valid half subnormal sitting in the first stage.
  logic sub1;

  assign sub1 = v1 && op1 == hsfc_pkg::OP_H2S && cls1 == hsfc_pkg::CLS_SUB;

  // A half result never sets the upper sixteen bits.
  `HSFC_ASSERT_NOW(a_half_upper_zero, v3 && op3 == hsfc_pkg::OP_S2H, result3[31:16] == 16'd0)
  // A half subnormal always has a set bit, so the count stays below the field width.
  `HSFC_ASSERT_NOW(a_sub_lz_range, sub1, lz1 < hsfc_pkg::LzW'(hsfc_pkg::HalfFracW))
  // A held middle stage keeps its transaction.
  `HSFC_ASSERT_NEXT(a_s2_hold, v2 && !en3, v2 && $stable(exp2) && $stable(frac2))
  // The input side is stalled only when every stage is full.
  `HSFC_ASSERT_NOW(a_stall_full, in_stall, v1 && v2 && v3 && out_stall)

endmodule

### bench/half_single_float_converter_tb.sv
// Self-checking testbench for the half/single float converter.
// Depends on hsfc_pkg and the half_single_float_converter RTL; runs a directed
// table, then random operands, under random idling on both channels.
`timescale 1ns / 100ps

module half_single_float_converter_tb;

  localparam int unsigned RandomCount = 1400;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned HoldAfter   = 900;

  // One row of the directed table; a row with known_result clear is checked
  // against the converter model instead of the typed value.
  typedef struct packed {
    hsfc_pkg::op_t op;
    logic [31:0]   operand;
    logic          known_result;
    logic [31:0]   result;
  } conv_vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = 1'b0;
  logic [31:0] operand_bits = 32'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] result_bits;

  logic [31:0] pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  conv_vector_t directed_vectors [0:21] = '{
    // Half to single: signed zeros, subnormal extremes, largest normal.
    '{hsfc_pkg::OP_H2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::OP_H2S, 32'h0000_8000, 1'b1, 32'h8000_0000},
    '{hsfc_pkg::OP_H2S, 32'h0000_0001, 1'b0, 32'h0},
    '{hsfc_pkg::OP_H2S, 32'h0000_03ff, 1'b0, 32'h0},
    '{hsfc_pkg::OP_H2S, 32'h0000_0200, 1'b0, 32'h0},
    '{hsfc_pkg::OP_H2S, 32'h0000_7bff, 1'b0, 32'h0},
    // Half infinities and an all-ones NaN payload.
    '{hsfc_pkg::OP_H2S, 32'h0000_7c00, 1'b1, 32'h7f80_0000},
    '{hsfc_pkg::OP_H2S, 32'h0000_fc00, 1'b1, 32'hff80_0000},
    '{hsfc_pkg::OP_H2S, 32'h0000_7fff, 1'b1, 32'h7fff_e000},
    // The upper half of a half operand must be ignored.
    '{hsfc_pkg::OP_H2S, 32'hffff_3c00, 1'b0, 32'h0},
    // Single to half: infinities and NaNs of either sign.
    '{hsfc_pkg::OP_S2H, 32'h7f80_0000, 1'b1, 32'h0000_7c00},
    '{hsfc_pkg::OP_S2H, 32'hff80_0000, 1'b1, 32'h0000_fc00},
    '{hsfc_pkg::OP_S2H, 32'h7f80_0001, 1'b1, 32'h0000_7c01},
    '{hsfc_pkg::OP_S2H, 32'hffff_ffff, 1'b1, 32'h0000_fc01},
    // Signed zeros, a single subnormal, and the range boundaries.
    '{hsfc_pkg::OP_S2H, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{hsfc_pkg::OP_S2H, 32'h8000_0000, 1'b1, 32'h0000_8000},
    '{hsfc_pkg::OP_S2H, 32'h007f_ffff, 1'b0, 32'h0},
    '{hsfc_pkg::OP_S2H, 32'h4780_0000, 1'b0, 32'h0},
    '{hsfc_pkg::OP_S2H, 32'hc77f_ffff, 1'b0, 32'h0},
    '{hsfc_pkg::OP_S2H, 32'h3880_0000, 1'b0, 32'h0},
    '{hsfc_pkg::OP_S2H, 32'h387f_ffff, 1'b0, 32'h0},
    // Low fraction bits are truncated, not rounded.
    '{hsfc_pkg::OP_S2H, 32'h3f80_1fff, 1'b0, 32'h0}
  };

  half_single_float_converter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .operand_bits (operand_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_bits  (result_bits)
  );

  // Widen a binary16 pattern to binary32; exact in every case.
  function automatic logic [31:0] half_to_single_bits(input logic [15:0] h);
    logic        sgn;
    logic [4:0]  hexp;
    logic [10:0] mant;
    logic [7:0]  shift;
    sgn  = h[15];
    hexp = h[14:10];
    mant = {1'b0, h[9:0]};
    shift = 8'd0;
    if (hexp == 5'd0) begin
      if (mant == 11'd0) begin
        return {sgn, 31'h0};
      end
      // Normalize the subnormal until the hidden bit position is set.
      while (!mant[10]) begin
        mant  = mant << 1;
        shift = shift + 8'd1;
      end
      return {sgn, hsfc_pkg::EXP_REBIAS + 8'd1 - shift, mant[9:0], 13'h0};
    end
    if (hexp == hsfc_pkg::HALF_EXP_MAX) begin
      return {sgn, hsfc_pkg::SINGLE_EXP_MAX, h[9:0], 13'h0};
    end
    return {sgn, {3'b000, hexp} + hsfc_pkg::EXP_REBIAS, h[9:0], 13'h0};
  endfunction

  // Narrow a binary32 pattern to binary16 by truncation, zero-extended.
  function automatic logic [31:0] single_to_half_bits(input logic [31:0] f);
    logic       sgn;
    logic [7:0] sexp;
    logic [7:0] hexp;
    sgn  = f[31];
    sexp = f[30:23];
    hexp = sexp - hsfc_pkg::EXP_REBIAS;
    if (sexp == hsfc_pkg::SINGLE_EXP_MAX) begin
      return {16'h0, sgn, hsfc_pkg::HALF_EXP_MAX, 9'h0, |f[22:0]};
    end
    if (sexp >= hsfc_pkg::S2H_OVF_EXP) begin
      return {16'h0, sgn, hsfc_pkg::HALF_EXP_MAX, 10'h0};
    end
    if (sexp <= hsfc_pkg::EXP_REBIAS) begin
      return {16'h0, sgn, 15'h0};
    end
    return {16'h0, sgn, hexp[4:0], f[22:13]};
  endfunction

  function automatic logic [31:0] converted_bits(input hsfc_pkg::op_t op,
                                                 input logic [31:0] val);
    if (op == hsfc_pkg::OP_H2S) begin
      return half_to_single_bits(val[15:0]);
    end
    return single_to_half_bits(val);
  endfunction

  // Random operand, biased toward exponents at the class boundaries.
  function automatic logic [31:0] pick_operand(input hsfc_pkg::op_t op);
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      return raw;
    end
    if (op == hsfc_pkg::OP_H2S) begin
      case ($urandom_range(0, 4))
        0: raw[14:10] = 5'd0;
        1: raw[14:10] = hsfc_pkg::HALF_EXP_MAX;
        2: raw[14:10] = 5'd1;
        3: raw[14:10] = 5'd30;
        default: ;
      endcase
      // A single set bit walks the subnormal shift count over its range.
      case ($urandom_range(0, 3))
        0: raw[9:0] = 10'h1 << $urandom_range(0, 9);
        1: raw[9:0] = 10'h0;
        default: ;
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0: raw[30:23] = 8'd0;
        1: raw[30:23] = hsfc_pkg::SINGLE_EXP_MAX;
        2: raw[30:23] = hsfc_pkg::EXP_REBIAS;
        3: raw[30:23] = hsfc_pkg::EXP_REBIAS + 8'd1;
        4: raw[30:23] = hsfc_pkg::S2H_OVF_EXP - 8'd1;
        5: raw[30:23] = hsfc_pkg::S2H_OVF_EXP;
        6: raw[30:23] = 8'd1;
        7: raw[30:23] = 8'd254;
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0: raw[22:0] = 23'h0;
        1: raw[22:0] = raw[22:0] & 23'h1fff;
        default: ;
      endcase
    end
    return raw;
  endfunction

  // Offer one operand, starting at a falling edge, and record its result
  // once the transaction is taken. Returns at the next falling edge.
  task automatic send_operand(input hsfc_pkg::op_t op, input logic [31:0] val,
                              input logic [31:0] want);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    operand_bits <= val;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_results.insert(pending_results.size(), want);
    sent_count = sent_count + 1;
    @(negedge clk);
  endtask

  // Free-running clock.
  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Run limit on the whole simulation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off, and a stretch with none.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else if (!hold_done && sent_count >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 29);
      end
    end
  end

  // Compare each accepted result with the oldest outstanding one.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $realtime,
                 result_bits);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (result_bits !== want) begin
          $display("%0t: result_bits mismatch: expected %h, actual %h", $realtime,
                   want, result_bits);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Stimulus: reset, directed table, random operands, then drain.
  initial begin
    hsfc_pkg::op_t op;
    logic [31:0]   val;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_vectors[i]) begin
      op  = directed_vectors[i].op;
      val = directed_vectors[i].operand;
      send_operand(op, val, directed_vectors[i].known_result ?
                   directed_vectors[i].result : converted_bits(op, val));
    end

    for (int n = 0; n < RandomCount; n++) begin
      no_idle = (n >= 400 && n < 650);
      op  = hsfc_pkg::op_t'($urandom_range(0, 1));
      val = pick_operand(op);
      send_operand(op, val, converted_bits(op, val));
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
